### design/kpdc_pkg.sv
// Shared types and constants for the key press duration classifier.
`default_nettype none

package kpdc_pkg;

	// Default width of the hold timer.
	localparam int TIMER_BITS_DEF = 16;

	// Field widths of the channels.
	localparam int ELAPSED_W   = 8;
	localparam int CODE_W      = 3;
	localparam int HOLD_W      = 16;
	localparam int CFG_INDEX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_RECEIPT_HOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RESET_HOLD   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CHECK_HOLD   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_HOLD = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [HOLD_W-1:0] RECEIPT_HOLD_RST = 16'd50;
	localparam logic [HOLD_W-1:0] STAGE_HOLD_RST   = 16'd3000;

	// Event codes.
	localparam logic [CODE_W-1:0] CODE_NONE        = 3'd0;
	localparam logic [CODE_W-1:0] CODE_RECEIPT     = 3'd1;
	localparam logic [CODE_W-1:0] CODE_RESET       = 3'd2;
	localparam logic [CODE_W-1:0] CODE_CHECK       = 3'd3;
	localparam logic [CODE_W-1:0] CODE_SET_DEFAULT = 3'd4;

	// Hold times of the four press stages.
	typedef struct packed {
		logic [HOLD_W-1:0] receipt_hold_ticks;
		logic [HOLD_W-1:0] reset_hold_ticks;
		logic [HOLD_W-1:0] check_hold_ticks;
		logic [HOLD_W-1:0] default_hold_ticks;
	} hold_cfg_t;

endpackage

`default_nettype wire

### design/kpdc_poll_if.sv
// Poll channel interface: key level, elapsed ticks and queried code.
`default_nettype none

interface kpdc_poll_if;
	logic                          valid;
	logic                          ready;
	logic                          key_level;
	logic [kpdc_pkg::ELAPSED_W-1:0] elapsed_ticks;
	logic [kpdc_pkg::CODE_W-1:0]    query_code;

	modport source (output valid, output key_level, output elapsed_ticks,
		output query_code, input ready);
	modport sink (input valid, input key_level, input elapsed_ticks,
		input query_code, output ready);
endinterface

`default_nettype wire

### design/kpdc_result_if.sv
// Result channel interface: one match flag per poll.
`default_nettype none

interface kpdc_result_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, output matched, input ready);
	modport sink (input valid, input matched, output ready);
endinterface

`default_nettype wire

### design/kpdc_cfg_if.sv
// Configuration write channel interface: register index and write data.
`default_nettype none

interface kpdc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [kpdc_pkg::CFG_INDEX_W-1:0] index;
	logic [kpdc_pkg::HOLD_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/key_press_duration_classifier.sv
// Top level of the key press duration classifier.
// Path: a poll is taken into the input register and its result is registered in the result register.
// Throughput: one poll per cycle; the input register is refilled while the
// result register is drained, and both stall together only when the result waits.
// Reset: arst_n clears the press state, timer and codes and restores the default
// hold times; no clearing pass follows.
`default_nettype none

module key_press_duration_classifier #(
	parameter int TIMER_BITS = kpdc_pkg::TIMER_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	kpdc_poll_if.sink    poll,
	kpdc_result_if.source result,
	kpdc_cfg_if.sink     cfg
);

	kpdc_pkg::hold_cfg_t          hold_cfg;
	logic                         valid_s1;
	logic                         key_s1;
	logic [kpdc_pkg::ELAPSED_W-1:0] elapsed_s1;
	logic [kpdc_pkg::CODE_W-1:0]    query_s1;
	logic                         valid_s2;
	logic                         matched_s2;
	logic                         adv_s1;
	logic                         step_matched;

	// The input stage moves on when the result register is empty or drained.
	assign adv_s1     = valid_s1 && (!valid_s2 || result.ready);
	assign poll.ready = !valid_s1 || adv_s1;

	kpdc_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.hold_cfg (hold_cfg)
	);

	kpdc_fsm #(
		.TIMER_BITS (TIMER_BITS)
	) u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (adv_s1),
		.key_level     (key_s1),
		.elapsed_ticks (elapsed_s1),
		.query_code    (query_s1),
		.hold_cfg      (hold_cfg),
		.matched       (step_matched)
	);

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (poll.ready)
			valid_s1 <= poll.valid;
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			key_s1     <= poll.key_level;
			elapsed_s1 <= poll.elapsed_ticks;
			query_s1   <= poll.query_code;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (!valid_s2 || result.ready)
			valid_s2 <= valid_s1;
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv_s1)
			matched_s2 <= step_matched;
	end

	assign result.valid   = valid_s2;
	assign result.matched = matched_s2;

endmodule

`default_nettype wire

### design/kpdc_cfg_regs.sv
// Configuration register file holding the four stage hold times.
`default_nettype none

module kpdc_cfg_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	kpdc_cfg_if.sink          cfg,
	output kpdc_pkg::hold_cfg_t hold_cfg
);

	kpdc_pkg::hold_cfg_t regs_q;

	// Writes are always taken.
	assign cfg.ready = 1'b1;
	assign hold_cfg  = regs_q;

	// Register writes on each configuration transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.receipt_hold_ticks <= kpdc_pkg::RECEIPT_HOLD_RST;
			regs_q.reset_hold_ticks   <= kpdc_pkg::STAGE_HOLD_RST;
			regs_q.check_hold_ticks   <= kpdc_pkg::STAGE_HOLD_RST;
			regs_q.default_hold_ticks <= kpdc_pkg::STAGE_HOLD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				kpdc_pkg::REG_RECEIPT_HOLD: regs_q.receipt_hold_ticks <= cfg.data;
				kpdc_pkg::REG_RESET_HOLD:   regs_q.reset_hold_ticks   <= cfg.data;
				kpdc_pkg::REG_CHECK_HOLD:   regs_q.check_hold_ticks   <= cfg.data;
				kpdc_pkg::REG_DEFAULT_HOLD: regs_q.default_hold_ticks <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### design/kpdc_fsm.sv
// Press stage state machine with hold timer and event code registers.
`default_nettype none

module kpdc_fsm #(
	parameter int TIMER_BITS = kpdc_pkg::TIMER_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step_en,
	input  wire logic                          key_level,
	input  wire logic [kpdc_pkg::ELAPSED_W-1:0] elapsed_ticks,
	input  wire logic [kpdc_pkg::CODE_W-1:0]    query_code,
	input  wire kpdc_pkg::hold_cfg_t            hold_cfg,
	output logic                               matched
);

	localparam logic [2:0] ST_UNPRESSED    = 3'd0;
	localparam logic [2:0] ST_WAIT_PRESS   = 3'd1;
	localparam logic [2:0] ST_RECEIPT      = 3'd2;
	localparam logic [2:0] ST_RESET        = 3'd3;
	localparam logic [2:0] ST_CHECK        = 3'd4;
	localparam logic [2:0] ST_SET_DEFAULT  = 3'd5;
	localparam logic [2:0] ST_WAIT_RELEASE = 3'd6;

	localparam int EXT_W = (TIMER_BITS > kpdc_pkg::HOLD_W) ? TIMER_BITS : kpdc_pkg::HOLD_W;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	logic [2:0]                   state_q, state_d;
	logic [TIMER_BITS-1:0]        count_q, count_d;
	logic [TIMER_BITS-1:0]        limit_q, limit_d;
	logic [kpdc_pkg::CODE_W-1:0]  pending_q, pending_d;
	logic [kpdc_pkg::CODE_W-1:0]  published_q, published_d;
	logic [TIMER_BITS:0]          count_sum;
	logic [TIMER_BITS-1:0]        count_sat;
	logic                         timer_done;
	logic                         stage_active;
	logic [kpdc_pkg::HOLD_W-1:0]  next_hold;
	logic [kpdc_pkg::CODE_W-1:0]  stage_code;
	logic [2:0]                   stage_next;

	// Clamp a hold time to the timer width.
	function automatic logic [TIMER_BITS-1:0] clamp_hold(input logic [kpdc_pkg::HOLD_W-1:0] t);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(t);
		if (ext > EXT_W'(TIMER_MAX))
			return TIMER_MAX;
		return TIMER_BITS'(ext);
	endfunction

	// Saturating tick accumulation and stage completion test.
	assign count_sum  = {1'b0, count_q} + (TIMER_BITS + 1)'(elapsed_ticks);
	assign count_sat  = count_sum[TIMER_BITS] ? TIMER_MAX : count_sum[TIMER_BITS-1:0];
	assign timer_done = (count_sat >= limit_q);

	// Successor's hold time, code and successor of the first three timed stages.
	always_comb begin
		stage_active = 1'b1;
		next_hold    = hold_cfg.reset_hold_ticks;
		stage_code   = kpdc_pkg::CODE_RECEIPT;
		stage_next   = ST_RESET;
		case (state_q)
			ST_RECEIPT: begin
				next_hold  = hold_cfg.reset_hold_ticks;
				stage_code = kpdc_pkg::CODE_RECEIPT;
				stage_next = ST_RESET;
			end
			ST_RESET: begin
				next_hold  = hold_cfg.check_hold_ticks;
				stage_code = kpdc_pkg::CODE_RESET;
				stage_next = ST_CHECK;
			end
			ST_CHECK: begin
				next_hold  = hold_cfg.default_hold_ticks;
				stage_code = kpdc_pkg::CODE_CHECK;
				stage_next = ST_SET_DEFAULT;
			end
			default: stage_active = 1'b0;
		endcase
	end

	// Next state, timer and codes for one poll, then the match and clear.
	always_comb begin
		state_d     = state_q;
		count_d     = count_sat;
		limit_d     = limit_q;
		pending_d   = pending_q;
		published_d = published_q;
		unique case (state_q) inside
			ST_UNPRESSED: begin
				published_d = pending_q;
				state_d     = ST_WAIT_PRESS;
			end
			ST_WAIT_PRESS: begin
				if (key_level) begin
					count_d = '0;
					limit_d = clamp_hold(hold_cfg.receipt_hold_ticks);
					state_d = ST_RECEIPT;
				end
			end
			ST_RECEIPT, ST_RESET, ST_CHECK: begin
				if (!key_level) begin
					published_d = pending_q;
					state_d     = ST_UNPRESSED;
				end else if (timer_done && stage_active) begin
					count_d   = '0;
					limit_d   = clamp_hold(next_hold);
					pending_d = stage_code;
					state_d   = stage_next;
				end
			end
			ST_SET_DEFAULT: begin
				if (!key_level) begin
					state_d = ST_UNPRESSED;
				end else if (timer_done) begin
					pending_d   = kpdc_pkg::CODE_SET_DEFAULT;
					published_d = kpdc_pkg::CODE_SET_DEFAULT;
					state_d     = ST_WAIT_RELEASE;
				end
			end
			ST_WAIT_RELEASE: begin
				if (!key_level)
					state_d = ST_UNPRESSED;
			end
			default: ;
		endcase

		matched = (published_d == query_code);
		if (matched) begin
			published_d = kpdc_pkg::CODE_NONE;
			pending_d   = kpdc_pkg::CODE_NONE;
		end
	end

	// State update on each poll that moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_UNPRESSED;
			count_q     <= '0;
			limit_q     <= '0;
			pending_q   <= kpdc_pkg::CODE_NONE;
			published_q <= kpdc_pkg::CODE_NONE;
		end else if (step_en) begin
			state_q     <= state_d;
			count_q     <= count_d;
			limit_q     <= limit_d;
			pending_q   <= pending_d;
			published_q <= published_d;
		end
	end

endmodule

`default_nettype wire

### design/kpdc_checker.sv
// Port-level checker for the key press duration classifier, with its bind.
`default_nettype none

module kpdc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic poll_valid,
	input wire logic poll_ready,
	input wire logic result_valid,
	input wire logic result_ready,
	input wire logic result_matched
);

	// An empty result register never holds back a poll.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> poll_ready)
		else $error("poll not accepted while result register is empty");

	// Every accepted poll is followed by a valid result from the result register.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(poll_valid && poll_ready) |-> ##2 result_valid)
		else $error("no result two cycles after a poll transfer");

	// A stalled result keeps its flag.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result_matched)))
		else $error("stalled result changed before transfer");

endmodule

bind key_press_duration_classifier kpdc_checker u_kpdc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.poll_valid     (poll.valid),
	.poll_ready     (poll.ready),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.result_matched (result.matched)
);

`default_nettype wire
